>>> sv/radial_tangential_distort_map_macros.svh
// ----------------------------------------------------------------------------
// radial_tangential_distort_map_macros
// assertion macros used by the lens distortion map top level
// ----------------------------------------------------------------------------
`ifndef RADIAL_TANGENTIAL_DISTORT_MAP_MACROS_SVH
`define RADIAL_TANGENTIAL_DISTORT_MAP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtd assertion failed (same cycle)");
`define RTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtd assertion failed (next cycle)");
`else
`define RTD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// types, constants and fixed-point helpers of the lens distortion map
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int IMG_WIDTH  = 1024;
   localparam int IMG_HEIGHT = 1024;
   localparam int SCALE_ONE  = 4096;

   typedef logic        [9:0]  coord_type;
   typedef logic        [23:0] color_type;
   typedef logic        [13:0] dest_type;
   typedef logic signed [31:0] coef_type;
   typedef logic signed [33:0] q_type;
   typedef logic signed [47:0] wide_type;
   typedef logic        [27:0] frame_type;
   typedef logic signed [13:0] diff_type;
   typedef logic        [12:0] mag_type;
   typedef logic        [55:0] recip_type;
   typedef logic        [68:0] nprod_type;
   typedef logic        [43:0] nquo_type;
   typedef logic signed [46:0] pprod_type;
   typedef logic signed [48:0] psum_type;
   typedef logic signed [16:0] pix_type;
   typedef logic        [2:0]  csr_idx_type;
   typedef logic        [31:0] csr_data_type;

   typedef struct packed {
      coef_type  k1;
      coef_type  k2;
      coef_type  k3;
      coef_type  k4;
      coef_type  p1;
      coef_type  p2;
      coef_type  skew;
      frame_type frame_w;
      frame_type frame_h;
   } cfg_type;

   // register indexes
   localparam csr_idx_type CSR_K1    = 3'd0;
   localparam csr_idx_type CSR_K2    = 3'd1;
   localparam csr_idx_type CSR_K3    = 3'd2;
   localparam csr_idx_type CSR_K4    = 3'd3;
   localparam csr_idx_type CSR_P1    = 3'd4;
   localparam csr_idx_type CSR_P2    = 3'd5;
   localparam csr_idx_type CSR_SKEW  = 3'd6;
   localparam csr_idx_type CSR_SCALE = 3'd7;

   localparam cfg_type CFG_RESET = '{
      k1:      '0,
      k2:      '0,
      k3:      '0,
      k4:      '0,
      p1:      '0,
      p2:      '0,
      skew:    '0,
      frame_w: frame_type'(IMG_WIDTH * SCALE_ONE),
      frame_h: frame_type'(IMG_HEIGHT * SCALE_ONE)
   };

   // pipeline depths
   localparam int NORM_LAT  = 2;
   localparam int DIST_LAT  = 10;
   localparam int PIX_LAT   = 3;
   localparam int TOTAL_LAT = NORM_LAT + DIST_LAT + PIX_LAT;

   // reciprocals for |2p - size| * 2^31 / size, exact with a 25-bit post shift
   localparam int        NORM_SHIFT = 25;
   localparam recip_type NORM_RX =
      recip_type'(((64'd1 << 56) + 64'(IMG_WIDTH) - 64'd1) / 64'(IMG_WIDTH));
   localparam recip_type NORM_RY =
      recip_type'(((64'd1 << 56) + 64'(IMG_HEIGHT) - 64'd1) / 64'(IMG_HEIGHT));
   localparam nquo_type  NORM_POS_LIM = nquo_type'(64'h1_FFFF_FFFF);
   localparam nquo_type  NORM_NEG_LIM = nquo_type'(64'h2_0000_0000);

   localparam q_type    Q_MAX   = {1'b0, {33{1'b1}}};
   localparam q_type    Q_MIN   = {1'b1, 33'd0};
   localparam wide_type Q_MAX_W = wide_type'(Q_MAX);
   localparam wide_type Q_MIN_W = wide_type'(Q_MIN);
   localparam wide_type Q_ONE_W = wide_type'(64'h1_0000_0000);

   localparam psum_type TRUNC_BIAS = psum_type'(64'hFFFF_FFFF);

   function automatic wide_type ext_q(input q_type v);
      return wide_type'(v);
   endfunction

   function automatic q_type sat_q(input wide_type v);
      q_type r;
      if (v > Q_MAX_W) begin
         r = Q_MAX;
      end else if (v < Q_MIN_W) begin
         r = Q_MIN;
      end else begin
         r = v[33:0];
      end
      return r;
   endfunction

   function automatic q_type sum3_q(input q_type a, input q_type b, input q_type c);
      return sat_q(ext_q(a) + ext_q(b) + ext_q(c));
   endfunction

   function automatic q_type sum2_q(input q_type a, input q_type b);
      return sat_q(ext_q(a) + ext_q(b));
   endfunction

   // q2.32 times q2.32, floor shift by 32, saturate
   function automatic q_type mul_qq(input q_type a, input q_type b);
      logic signed [67:0] p;
      p = a * b;
      return sat_q(wide_type'($signed(p[67:32])));
   endfunction

   // q8.24 times q2.32, floor shift by 24, saturate
   function automatic q_type mul_cq(input coef_type c, input q_type b);
      logic signed [65:0] p;
      p = c * b;
      return sat_q(wide_type'($signed(p[65:24])));
   endfunction

endpackage

>>> sv/radial_tangential_distort_map.sv
// ----------------------------------------------------------------------------
// radial_tangential_distort_map
// pipelined lens distortion map: source pixel in, destination pixel out
//
//   channel    direction   handshake
//   request    in          start, busy
//   response   out         rsp_strobe, one cycle, no back-pressure
//   csr        in          csr_valid, csr_ready
//
// one request per clock while busy is low; pipeline depth in stages per block
// (normalizer 2, distortion 10, pixel mapper 3)
// busy is held high and csr_ready low during reset and the first cycle after it
// the response side cannot stall, so the pipeline advances every cycle
// ----------------------------------------------------------------------------
`include "radial_tangential_distort_map_macros.svh"

module radial_tangential_distort_map (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rtd_pkg::coord_type    req_src_col,
   input  rtd_pkg::coord_type    req_src_row,
   input  rtd_pkg::color_type    req_pixel_color,
   output logic                  rsp_strobe,
   output rtd_pkg::dest_type     rsp_dest_col,
   output rtd_pkg::dest_type     rsp_dest_row,
   output rtd_pkg::color_type    rsp_out_color,
   output logic                  rsp_write_valid,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rtd_pkg::csr_idx_type  csr_index,
   input  rtd_pkg::csr_data_type csr_wdata
);

   logic               busy_ff;
   logic               req_accept;
   rtd_pkg::cfg_type   cfg;
   logic               norm_valid;
   rtd_pkg::q_type     nx;
   rtd_pkg::q_type     ny;
   logic               dist_valid;
   rtd_pkg::q_type     xs;
   rtd_pkg::q_type     yd;
   rtd_pkg::color_type color_ff [rtd_pkg::TOTAL_LAT];

   assign req_accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // color rides alongside the datapath
   always_ff @(posedge clock) begin
      color_ff[0] <= req_pixel_color;
      for (int i = 1; i < rtd_pkg::TOTAL_LAT; i++) begin
         color_ff[i] <= color_ff[i-1];
      end
   end

   rtd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rtd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .src_col   (req_src_col),
      .src_row   (req_src_row),
      .out_valid (norm_valid),
      .nx        (nx),
      .ny        (ny)
   );

   rtd_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .nx        (nx),
      .ny        (ny),
      .cfg       (cfg),
      .out_valid (dist_valid),
      .xs        (xs),
      .yd        (yd)
   );

   rtd_pixel u_pixel (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dist_valid),
      .xs          (xs),
      .yd          (yd),
      .cfg         (cfg),
      .out_valid   (rsp_strobe),
      .dest_col    (rsp_dest_col),
      .dest_row    (rsp_dest_row),
      .write_valid (rsp_write_valid)
   );

   assign busy          = busy_ff;
   assign rsp_out_color = color_ff[rtd_pkg::TOTAL_LAT-1];

   `RTD_ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_strobe, $past(req_accept, rtd_pkg::TOTAL_LAT))
   `RTD_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_strobe && !rsp_write_valid, rsp_dest_col == '0 && rsp_dest_row == '0)
   `RTD_ASSERT_IMPLY(a_inside_frame, clock, reset, rsp_strobe && rsp_write_valid, ({rsp_dest_col, 12'd0} < cfg.frame_w) && ({rsp_dest_row, 12'd0} < cfg.frame_h))
   `RTD_ASSERT_NEXT(a_busy_stays_low, clock, reset, !busy, !busy)

endmodule

>>> sv/rtd_csr.sv
// ----------------------------------------------------------------------------
// rtd_csr
// coefficient registers and precomputed scaled frame size
// ----------------------------------------------------------------------------
module rtd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rtd_pkg::csr_idx_type  csr_index,
   input  rtd_pkg::csr_data_type csr_wdata,
   output rtd_pkg::cfg_type      cfg
);

   rtd_pkg::cfg_type cfg_ff;
   rtd_pkg::cfg_type cfg_in;
   logic             ready_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && ready_ff) begin
         case (csr_index)
            rtd_pkg::CSR_K1:   cfg_in.k1   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_K2:   cfg_in.k2   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_K3:   cfg_in.k3   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_K4:   cfg_in.k4   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_P1:   cfg_in.p1   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_P2:   cfg_in.p2   = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_SKEW: cfg_in.skew = rtd_pkg::coef_type'(csr_wdata);
            rtd_pkg::CSR_SCALE: begin
               cfg_in.frame_w = rtd_pkg::frame_type'(rtd_pkg::IMG_WIDTH)
                              * rtd_pkg::frame_type'(csr_wdata[15:0]);
               cfg_in.frame_h = rtd_pkg::frame_type'(rtd_pkg::IMG_HEIGHT)
                              * rtd_pkg::frame_type'(csr_wdata[15:0]);
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= rtd_pkg::CFG_RESET;
         ready_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         ready_ff <= 1'b1;
      end
   end

   assign cfg       = cfg_ff;
   assign csr_ready = ready_ff;

endmodule

>>> sv/rtd_norm.sv
// ----------------------------------------------------------------------------
// rtd_norm
// coordinate normalization by reciprocal multiply, two stages
// ----------------------------------------------------------------------------
module rtd_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rtd_pkg::coord_type  src_col,
   input  rtd_pkg::coord_type  src_row,
   output logic                out_valid,
   output rtd_pkg::q_type      nx,
   output rtd_pkg::q_type      ny
);

   rtd_pkg::diff_type  dx;
   rtd_pkg::diff_type  dy;
   rtd_pkg::mag_type   mag_x;
   rtd_pkg::mag_type   mag_y;
   rtd_pkg::nquo_type  quo_x;
   rtd_pkg::nquo_type  quo_y;
   rtd_pkg::q_type     nx_in;
   rtd_pkg::q_type     ny_in;

   rtd_pkg::nprod_type prod_x_ff;
   rtd_pkg::nprod_type prod_y_ff;
   logic               neg_x_ff;
   logic               neg_y_ff;
   rtd_pkg::q_type     nx_ff;
   rtd_pkg::q_type     ny_ff;
   logic [rtd_pkg::NORM_LAT-1:0] valid_ff;

   // stage 1: magnitude of 2p - size times reciprocal
   always_comb begin
      dx    = rtd_pkg::diff_type'({src_col, 1'b0}) - rtd_pkg::diff_type'(rtd_pkg::IMG_WIDTH);
      dy    = rtd_pkg::diff_type'({src_row, 1'b0}) - rtd_pkg::diff_type'(rtd_pkg::IMG_HEIGHT);
      mag_x = dx[13] ? rtd_pkg::mag_type'(-dx) : rtd_pkg::mag_type'(dx);
      mag_y = dy[13] ? rtd_pkg::mag_type'(-dy) : rtd_pkg::mag_type'(dy);
   end

   // stage 2: post shift, saturate, restore sign
   always_comb begin
      quo_x = prod_x_ff[68:rtd_pkg::NORM_SHIFT];
      quo_y = prod_y_ff[68:rtd_pkg::NORM_SHIFT];
      if (neg_x_ff) begin
         nx_in = (quo_x > rtd_pkg::NORM_NEG_LIM) ? rtd_pkg::Q_MIN
                                                 : rtd_pkg::q_type'(34'd0 - quo_x[33:0]);
      end else begin
         nx_in = (quo_x > rtd_pkg::NORM_POS_LIM) ? rtd_pkg::Q_MAX
                                                 : rtd_pkg::q_type'(quo_x[33:0]);
      end
      if (neg_y_ff) begin
         ny_in = (quo_y > rtd_pkg::NORM_NEG_LIM) ? rtd_pkg::Q_MIN
                                                 : rtd_pkg::q_type'(34'd0 - quo_y[33:0]);
      end else begin
         ny_in = (quo_y > rtd_pkg::NORM_POS_LIM) ? rtd_pkg::Q_MAX
                                                 : rtd_pkg::q_type'(quo_y[33:0]);
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= rtd_pkg::nprod_type'(mag_x) * rtd_pkg::nprod_type'(rtd_pkg::NORM_RX);
      prod_y_ff <= rtd_pkg::nprod_type'(mag_y) * rtd_pkg::nprod_type'(rtd_pkg::NORM_RY);
      neg_x_ff  <= dx[13];
      neg_y_ff  <= dy[13];
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[rtd_pkg::NORM_LAT-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[rtd_pkg::NORM_LAT-1];
   assign nx        = nx_ff;
   assign ny        = ny_ff;

endmodule

>>> sv/rtd_distort.sv
// ----------------------------------------------------------------------------
// rtd_distort
// radial, tangential and skew distortion, ten pipeline stages
// ----------------------------------------------------------------------------
module rtd_distort (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  rtd_pkg::q_type   nx,
   input  rtd_pkg::q_type   ny,
   input  rtd_pkg::cfg_type cfg,
   output logic             out_valid,
   output rtd_pkg::q_type   xs,
   output rtd_pkg::q_type   yd
);

   // stage 1
   rtd_pkg::q_type nxx1_ff, nyy1_ff, nxy1_ff, nx1_ff, ny1_ff;
   // stage 2
   rtd_pkg::q_type r2_2_ff, nxx2_ff, nyy2_ff, nxy2_ff, nx2_ff, ny2_ff;
   // stage 3
   rtd_pkg::q_type r2_3_ff, r4_3_ff, k1r2_3_ff, sx3_ff, sy3_ff;
   rtd_pkg::q_type p1xy3_ff, p2xy3_ff, nx3_ff, ny3_ff;
   // stage 4
   rtd_pkg::q_type r6_4_ff, r8_4_ff, k2r4_4_ff, p2sx4_ff, p1sy4_ff;
   rtd_pkg::q_type k1r2_4_ff, p1xy4_ff, p2xy4_ff, nx4_ff, ny4_ff;
   // stage 5
   rtd_pkg::q_type k3r6_5_ff, k4r8_5_ff, tx5_ff, ty5_ff;
   rtd_pkg::q_type k1r2_5_ff, k2r4_5_ff, nx5_ff, ny5_ff;
   // stage 6
   rtd_pkg::q_type rad6_ff, tx6_ff, ty6_ff, nx6_ff, ny6_ff;
   // stage 7
   rtd_pkg::q_type xr7_ff, yr7_ff, tx7_ff, ty7_ff;
   // stage 8
   rtd_pkg::q_type xd8_ff, yd8_ff;
   // stage 9
   rtd_pkg::q_type sk9_ff, xd9_ff, yd9_ff;
   // stage 10
   rtd_pkg::q_type xs10_ff, yd10_ff;

   logic [rtd_pkg::DIST_LAT-1:0] valid_ff;

   always_ff @(posedge clock) begin
      nxx1_ff   <= rtd_pkg::mul_qq(nx, nx);
      nyy1_ff   <= rtd_pkg::mul_qq(ny, ny);
      nxy1_ff   <= rtd_pkg::mul_qq(nx, ny);
      nx1_ff    <= nx;
      ny1_ff    <= ny;

      r2_2_ff   <= rtd_pkg::sum2_q(nxx1_ff, nyy1_ff);
      nxx2_ff   <= nxx1_ff;
      nyy2_ff   <= nyy1_ff;
      nxy2_ff   <= nxy1_ff;
      nx2_ff    <= nx1_ff;
      ny2_ff    <= ny1_ff;

      r2_3_ff   <= r2_2_ff;
      r4_3_ff   <= rtd_pkg::mul_qq(r2_2_ff, r2_2_ff);
      k1r2_3_ff <= rtd_pkg::mul_cq(cfg.k1, r2_2_ff);
      sx3_ff    <= rtd_pkg::sum3_q(r2_2_ff, nxx2_ff, nxx2_ff);
      sy3_ff    <= rtd_pkg::sum3_q(r2_2_ff, nyy2_ff, nyy2_ff);
      p1xy3_ff  <= rtd_pkg::mul_cq(cfg.p1, nxy2_ff);
      p2xy3_ff  <= rtd_pkg::mul_cq(cfg.p2, nxy2_ff);
      nx3_ff    <= nx2_ff;
      ny3_ff    <= ny2_ff;

      r6_4_ff   <= rtd_pkg::mul_qq(r2_3_ff, r4_3_ff);
      r8_4_ff   <= rtd_pkg::mul_qq(r4_3_ff, r4_3_ff);
      k2r4_4_ff <= rtd_pkg::mul_cq(cfg.k2, r4_3_ff);
      p2sx4_ff  <= rtd_pkg::mul_cq(cfg.p2, sx3_ff);
      p1sy4_ff  <= rtd_pkg::mul_cq(cfg.p1, sy3_ff);
      k1r2_4_ff <= k1r2_3_ff;
      p1xy4_ff  <= p1xy3_ff;
      p2xy4_ff  <= p2xy3_ff;
      nx4_ff    <= nx3_ff;
      ny4_ff    <= ny3_ff;

      k3r6_5_ff <= rtd_pkg::mul_cq(cfg.k3, r6_4_ff);
      k4r8_5_ff <= rtd_pkg::mul_cq(cfg.k4, r8_4_ff);
      tx5_ff    <= rtd_pkg::sum3_q(p1xy4_ff, p1xy4_ff, p2sx4_ff);
      ty5_ff    <= rtd_pkg::sum3_q(p1sy4_ff, p2xy4_ff, p2xy4_ff);
      k1r2_5_ff <= k1r2_4_ff;
      k2r4_5_ff <= k2r4_4_ff;
      nx5_ff    <= nx4_ff;
      ny5_ff    <= ny4_ff;

      rad6_ff   <= rtd_pkg::sat_q(rtd_pkg::Q_ONE_W + rtd_pkg::ext_q(k1r2_5_ff)
                                  + rtd_pkg::ext_q(k2r4_5_ff) + rtd_pkg::ext_q(k3r6_5_ff)
                                  + rtd_pkg::ext_q(k4r8_5_ff));
      tx6_ff    <= tx5_ff;
      ty6_ff    <= ty5_ff;
      nx6_ff    <= nx5_ff;
      ny6_ff    <= ny5_ff;

      xr7_ff    <= rtd_pkg::mul_qq(nx6_ff, rad6_ff);
      yr7_ff    <= rtd_pkg::mul_qq(ny6_ff, rad6_ff);
      tx7_ff    <= tx6_ff;
      ty7_ff    <= ty6_ff;

      xd8_ff    <= rtd_pkg::sum2_q(xr7_ff, tx7_ff);
      yd8_ff    <= rtd_pkg::sum2_q(yr7_ff, ty7_ff);

      sk9_ff    <= rtd_pkg::mul_cq(cfg.skew, yd8_ff);
      xd9_ff    <= xd8_ff;
      yd9_ff    <= yd8_ff;

      xs10_ff   <= rtd_pkg::sum2_q(xd9_ff, sk9_ff);
      yd10_ff   <= yd9_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[rtd_pkg::DIST_LAT-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[rtd_pkg::DIST_LAT-1];
   assign xs        = xs10_ff;
   assign yd        = yd10_ff;

endmodule

>>> sv/rtd_pixel.sv
// ----------------------------------------------------------------------------
// rtd_pixel
// scale back to pixels, recenter, truncate and check the output frame
// ----------------------------------------------------------------------------
module rtd_pixel (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  rtd_pkg::q_type     xs,
   input  rtd_pkg::q_type     yd,
   input  rtd_pkg::cfg_type   cfg,
   output logic               out_valid,
   output rtd_pkg::dest_type  dest_col,
   output rtd_pkg::dest_type  dest_row,
   output logic               write_valid
);

   rtd_pkg::psum_type  sum_x;
   rtd_pkg::psum_type  sum_y;
   rtd_pkg::psum_type  adj_x;
   rtd_pkg::psum_type  adj_y;
   logic               ok_x;
   logic               ok_y;
   logic               ok;

   rtd_pkg::pprod_type px_ff;
   rtd_pkg::pprod_type py_ff;
   rtd_pkg::pix_type   xn_ff;
   rtd_pkg::pix_type   yn_ff;
   rtd_pkg::dest_type  dest_col_ff;
   rtd_pkg::dest_type  dest_row_ff;
   logic               write_valid_ff;
   logic [rtd_pkg::PIX_LAT-1:0] valid_ff;

   // add scaled center, truncate toward zero
   always_comb begin
      sum_x = rtd_pkg::psum_type'(px_ff) + rtd_pkg::psum_type'({cfg.frame_w, 19'd0});
      sum_y = rtd_pkg::psum_type'(py_ff) + rtd_pkg::psum_type'({cfg.frame_h, 19'd0});
      adj_x = sum_x + (sum_x[48] ? rtd_pkg::TRUNC_BIAS : rtd_pkg::psum_type'(0));
      adj_y = sum_y + (sum_y[48] ? rtd_pkg::TRUNC_BIAS : rtd_pkg::psum_type'(0));
   end

   // frame check
   always_comb begin
      ok_x = !xn_ff[16] && (xn_ff[15:14] == 2'd0)
             && (rtd_pkg::frame_type'({xn_ff[15:0], 12'd0}) < cfg.frame_w);
      ok_y = !yn_ff[16] && (yn_ff[15:14] == 2'd0)
             && (rtd_pkg::frame_type'({yn_ff[15:0], 12'd0}) < cfg.frame_h);
      ok   = ok_x && ok_y;
   end

   always_ff @(posedge clock) begin
      px_ff          <= rtd_pkg::pprod_type'(xs) * rtd_pkg::pprod_type'(rtd_pkg::IMG_WIDTH);
      py_ff          <= rtd_pkg::pprod_type'(yd) * rtd_pkg::pprod_type'(rtd_pkg::IMG_HEIGHT);
      xn_ff          <= adj_x[48:32];
      yn_ff          <= adj_y[48:32];
      dest_col_ff    <= ok ? xn_ff[13:0] : '0;
      dest_row_ff    <= ok ? yn_ff[13:0] : '0;
      write_valid_ff <= ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[rtd_pkg::PIX_LAT-2:0], in_valid};
      end
   end

   assign out_valid   = valid_ff[rtd_pkg::PIX_LAT-1];
   assign dest_col    = dest_col_ff;
   assign dest_row    = dest_row_ff;
   assign write_valid = write_valid_ff;

endmodule

>>> tb/radial_tangential_distort_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_tangential_distort_map_test
// self-checking bench for the lens distortion map: requests come from a
// pending queue, a fixed-point predictor computes each destination pixel,
// and every response is compared in order against the predicted one over
// directed corner cases and randomized coefficient settings
// ----------------------------------------------------------------------------
module radial_tangential_distort_map_test;

   typedef logic signed [127:0] big_type;

   typedef struct packed {
      rtd_pkg::coord_type col;
      rtd_pkg::coord_type row;
      rtd_pkg::color_type rgb;
   } pixel_req_type;

   typedef struct packed {
      rtd_pkg::dest_type  col;
      rtd_pkg::dest_type  row;
      rtd_pkg::color_type rgb;
      logic               wr;
   } mapped_pixel_type;

   localparam longint Q_UNIT   = 64'sh1_0000_0000;
   localparam longint Q_TOP    = 64'sh1_FFFF_FFFF;
   localparam longint Q_BOT    = -64'sh2_0000_0000;
   localparam longint DEST_TOP = 16383;
   localparam int     IDLE_PCT = 12;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   rtd_pkg::coord_type    req_src_col     = '0;
   rtd_pkg::coord_type    req_src_row     = '0;
   rtd_pkg::color_type    req_pixel_color = '0;
   logic                  rsp_strobe;
   rtd_pkg::dest_type     rsp_dest_col;
   rtd_pkg::dest_type     rsp_dest_row;
   rtd_pkg::color_type    rsp_out_color;
   logic                  rsp_write_valid;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   rtd_pkg::csr_idx_type  csr_index = '0;
   rtd_pkg::csr_data_type csr_wdata = '0;

   pixel_req_type    pending_q[$];
   mapped_pixel_type mapped_q[$];
   longint           cfg_reg[8];
   bit               steady_feed = 1'b0;
   int               err_count   = 0;

   radial_tangential_distort_map u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_src_col     (req_src_col),
      .req_src_row     (req_src_row),
      .req_pixel_color (req_pixel_color),
      .rsp_strobe      (rsp_strobe),
      .rsp_dest_col    (rsp_dest_col),
      .rsp_dest_row    (rsp_dest_row),
      .rsp_out_color   (rsp_out_color),
      .rsp_write_valid (rsp_write_valid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic longint clamp34(input big_type v);
      if (v > big_type'(Q_TOP)) begin
         return Q_TOP;
      end
      if (v < big_type'(Q_BOT)) begin
         return Q_BOT;
      end
      return longint'(v);
   endfunction

   // full product, floor shift, saturate
   function automatic longint fmul(input longint a, input longint b, input int sh);
      big_type p;
      p = big_type'(a) * big_type'(b);
      return clamp34(p >>> sh);
   endfunction

   function automatic longint to_dest(input longint v, input longint size);
      return (v * size + size * cfg_reg[rtd_pkg::CSR_SCALE] * (longint'(1) <<< 19)) / Q_UNIT;
   endfunction

   function automatic mapped_pixel_type map_pixel(input rtd_pkg::coord_type c,
                                                  input rtd_pkg::coord_type r,
                                                  input rtd_pkg::color_type rgb);
      longint nx, ny, nxx, nyy, nxy, r2, r4, r6, r8, rad, tx, ty, xd, yd, xs, xn, yn;
      longint k1, k2, k3, k4, p1, p2, sk, sc;
      mapped_pixel_type m;
      k1  = cfg_reg[rtd_pkg::CSR_K1];
      k2  = cfg_reg[rtd_pkg::CSR_K2];
      k3  = cfg_reg[rtd_pkg::CSR_K3];
      k4  = cfg_reg[rtd_pkg::CSR_K4];
      p1  = cfg_reg[rtd_pkg::CSR_P1];
      p2  = cfg_reg[rtd_pkg::CSR_P2];
      sk  = cfg_reg[rtd_pkg::CSR_SKEW];
      sc  = cfg_reg[rtd_pkg::CSR_SCALE];
      nx  = clamp34(big_type'(((longint'(c) * 2 - rtd_pkg::IMG_WIDTH) * (longint'(1) <<< 31))
                              / rtd_pkg::IMG_WIDTH));
      ny  = clamp34(big_type'(((longint'(r) * 2 - rtd_pkg::IMG_HEIGHT) * (longint'(1) <<< 31))
                              / rtd_pkg::IMG_HEIGHT));
      nxx = fmul(nx, nx, 32);
      nyy = fmul(ny, ny, 32);
      nxy = fmul(nx, ny, 32);
      r2  = clamp34(big_type'(nxx + nyy));
      r4  = fmul(r2, r2, 32);
      r6  = fmul(r2, r4, 32);
      r8  = fmul(r4, r4, 32);
      rad = clamp34(big_type'(Q_UNIT + fmul(k1, r2, 24) + fmul(k2, r4, 24)
                              + fmul(k3, r6, 24) + fmul(k4, r8, 24)));
      tx  = clamp34(big_type'(2 * fmul(p1, nxy, 24)
                              + fmul(p2, clamp34(big_type'(r2 + 2 * nxx)), 24)));
      ty  = clamp34(big_type'(fmul(p1, clamp34(big_type'(r2 + 2 * nyy)), 24)
                              + 2 * fmul(p2, nxy, 24)));
      xd  = clamp34(big_type'(fmul(nx, rad, 32) + tx));
      yd  = clamp34(big_type'(fmul(ny, rad, 32) + ty));
      xs  = clamp34(big_type'(xd + fmul(sk, yd, 24)));
      xn  = to_dest(xs, rtd_pkg::IMG_WIDTH);
      yn  = to_dest(yd, rtd_pkg::IMG_HEIGHT);
      m.wr = xn >= 0 && yn >= 0 && xn <= DEST_TOP && yn <= DEST_TOP
             && xn * rtd_pkg::SCALE_ONE < rtd_pkg::IMG_WIDTH * sc
             && yn * rtd_pkg::SCALE_ONE < rtd_pkg::IMG_HEIGHT * sc;
      m.col = m.wr ? xn[13:0] : '0;
      m.row = m.wr ? yn[13:0] : '0;
      m.rgb = rgb;
      return m;
   endfunction

   function automatic rtd_pkg::csr_data_type rand_coef();
      rtd_pkg::csr_data_type v;
      int unsigned           mag;
      if ($urandom_range(7) == 0) begin
         return $urandom;
      end
      mag = $urandom_range(31, 8);
      v = $urandom & ((32'd1 << mag) - 32'd1);
      if ($urandom_range(1) == 1) begin
         v = -v;
      end
      return v;
   endfunction

   function automatic rtd_pkg::csr_data_type rand_scale();
      rtd_pkg::csr_data_type v;
      v = $urandom;
      case ($urandom_range(5))
         0: begin
            v[15:0] = 16'd1;
         end
         1: begin
            v[15:0] = 16'hFFFF;
         end
         2: begin
            v[15:0] = 16'($urandom_range(65535, 1));
         end
         default: begin
            v[15:0] = 16'($urandom_range(8192, 2048));
         end
      endcase
      return v;
   endfunction

   task automatic write_reg(input rtd_pkg::csr_idx_type idx,
                            input rtd_pkg::csr_data_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      cfg_reg[idx] = (idx == rtd_pkg::CSR_SCALE) ? longint'(data[15:0])
                                                 : longint'(signed'(data));
      csr_valid <= 1'b0;
   endtask

   task automatic add_pixel(input int col, input int row, input rtd_pkg::color_type rgb);
      pending_q.push_back('{col: rtd_pkg::coord_type'(col), row: rtd_pkg::coord_type'(row),
                            rgb: rgb});
   endtask

   task automatic add_random_pixels(input int count);
      for (int n = 0; n < count; n++) begin
         add_pixel($urandom_range(1023), $urandom_range(1023),
                   rtd_pkg::color_type'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || mapped_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // request driver
   always @(posedge clock) begin : driver
      pixel_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            mapped_q.push_back(map_pixel(req_src_col, req_src_row, req_pixel_color));
            void'(pending_q.pop_front());
         end
         if (!(start && busy)) begin
            if (pending_q.size() != 0 && (steady_feed || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_q[0];
               start           <= 1'b1;
               req_src_col     <= nxt.col;
               req_src_row     <= nxt.row;
               req_pixel_color <= nxt.rgb;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      mapped_pixel_type want;
      if (!reset && rsp_strobe) begin
         if (mapped_q.size() == 0) begin
            if (err_count < 10) begin
               $display("response with no request outstanding: col %0d row %0d",
                        rsp_dest_col, rsp_dest_row);
            end
            err_count++;
         end else begin
            want = mapped_q.pop_front();
            if (rsp_dest_col !== want.col || rsp_dest_row !== want.row
                || rsp_out_color !== want.rgb || rsp_write_valid !== want.wr) begin
               if (err_count < 10) begin
                  $display("mismatch: expected col %0d row %0d color %06h write %0b, %s",
                           want.col, want.row, want.rgb, want.wr, "got");
                  $display("          actual   col %0d row %0d color %06h write %0b",
                           rsp_dest_col, rsp_dest_row, rsp_out_color, rsp_write_valid);
               end
               err_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      cfg_reg = '{default: 0};
      cfg_reg[rtd_pkg::CSR_SCALE] = rtd_pkg::SCALE_ONE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: identity map
      @(negedge clock);
      add_pixel(0, 0, 24'h000000);
      add_pixel(1023, 1023, 24'hFFFFFF);
      add_pixel(0, 1023, 24'hAAAAAA);
      add_pixel(1023, 0, 24'h555555);
      add_pixel(512, 512, 24'h0F0F0F);
      add_pixel(511, 513, 24'hF0F0F0);
      add_pixel(1, 1022, 24'h123456);
      wait_drained();

      // slight pincushion: corners land just below zero and truncate to 0
      write_reg(rtd_pkg::CSR_K1, 32'h0000_8000);
      @(negedge clock);
      add_pixel(0, 0, 24'h800001);
      add_pixel(0, 512, 24'h010080);
      add_pixel(512, 0, 24'hC3C3C3);
      add_pixel(0, 1023, 24'h3C3C3C);
      wait_drained();

      // largest coefficients and scale, saturation everywhere
      for (int i = rtd_pkg::CSR_K1; i <= rtd_pkg::CSR_SKEW; i++) begin
         write_reg(rtd_pkg::csr_idx_type'(i), 32'h7FFF_FFFF);
      end
      write_reg(rtd_pkg::CSR_SCALE, 32'hFFFF_FFFF);
      @(negedge clock);
      add_pixel(0, 0, 24'h111111);
      add_pixel(1023, 1023, 24'h222222);
      add_pixel(512, 512, 24'h333333);
      add_pixel(100, 900, 24'h444444);
      wait_drained();

      // most negative coefficients, smallest nonzero scale
      for (int i = rtd_pkg::CSR_K1; i <= rtd_pkg::CSR_SKEW; i++) begin
         write_reg(rtd_pkg::csr_idx_type'(i), 32'h8000_0000);
      end
      write_reg(rtd_pkg::CSR_SCALE, 32'h0000_0001);
      @(negedge clock);
      add_pixel(0, 0, 24'h666666);
      add_pixel(1023, 1023, 24'h777777);
      add_pixel(512, 512, 24'h888888);
      add_pixel(900, 100, 24'h999999);
      wait_drained();

      // zero scale: empty frame
      for (int i = rtd_pkg::CSR_K1; i <= rtd_pkg::CSR_SKEW; i++) begin
         write_reg(rtd_pkg::csr_idx_type'(i), 32'h0000_0000);
      end
      write_reg(rtd_pkg::CSR_SCALE, 32'hFFFF_0000);
      @(negedge clock);
      add_pixel(512, 512, 24'hABCDEF);
      add_pixel(0, 0, 24'hFEDCBA);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         for (int i = rtd_pkg::CSR_K1; i <= rtd_pkg::CSR_SCALE; i++) begin
            write_reg(rtd_pkg::csr_idx_type'(i),
                      (i == rtd_pkg::CSR_SCALE) ? rand_scale() : rand_coef());
         end
         steady_feed = (phase == 3);
         @(negedge clock);
         add_random_pixels(108);
         wait_drained();
      end
      steady_feed = 1'b0;

      repeat (rtd_pkg::TOTAL_LAT + 4) @(posedge clock);
      err_count += mapped_q.size();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+sv
sv/rtd_pkg.sv
sv/rtd_csr.sv
sv/rtd_norm.sv
sv/rtd_distort.sv
sv/rtd_pixel.sv
sv/radial_tangential_distort_map.sv
tb/radial_tangential_distort_map_test.sv
